// ===== src/hass_pkg.sv =====
`timescale 1ns / 1ps

package hass_pkg;

   localparam int GRID_MAX_DEF    = 64;
   localparam int SAMPLE_BITS_DEF = 24;
   localparam int GRID_MIN        = 3;
   localparam int COEF_BITS       = 18;
   localparam int FRAC_BITS       = 17;
   localparam int POS_BITS        = 6;
   localparam int SIZE_BITS       = 7;
   localparam int CSR_IDX_BITS    = 3;
   localparam int CSR_DATA_BITS   = 18;

   localparam logic [SIZE_BITS-1:0] GRID_SIZE_RST  = 7'd40;
   localparam logic [SIZE_BITS-1:0] SPLIT_RST      = 7'd20;
   localparam logic signed [COEF_BITS-1:0] LEFT_COEF_RST  = 18'sd4194;
   localparam logic signed [COEF_BITS-1:0] RIGHT_COEF_RST = 18'sd1049;
   localparam logic signed [COEF_BITS-1:0] ADV_COEF_RST   = 18'sd0;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GRID_SIZE    = 3'd0,
      CSR_SPLIT_COLUMN = 3'd1,
      CSR_LEFT_COEF    = 3'd2,
      CSR_RIGHT_COEF   = 3'd3,
      CSR_ADV_COEF     = 3'd4
   } csr_index_type;

   // per-item control carried down the update pipeline
   typedef struct packed {
      logic                has_pt;
      logic                has_cp;
      logic                pt_copy;
      logic                right;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
      logic                done;
   } meta_type;

endpackage

// ===== src/hass_cell.sv =====
`timescale 1ns / 1ps

module hass_cell
   import hass_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   shift_en,
   input  logic                   load,
   input  logic [SAMPLE_BITS-1:0] new_data,
   input  logic [SAMPLE_BITS-1:0] prev_data,
   output logic [SAMPLE_BITS-1:0] data_out
);

   logic [SAMPLE_BITS-1:0] data_ff;
   logic [SAMPLE_BITS-1:0] data_in;

   assign data_in  = load ? new_data : prev_data;
   assign data_out = data_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== src/hass_line.sv =====
`timescale 1ns / 1ps

module hass_line
   import hass_pkg::*;
#(
   parameter int GRID_MAX    = GRID_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int XW         = $clog2(GRID_MAX)
) (
   input  logic                   clock,
   input  logic                   shift_en,
   input  logic [XW-1:0]          insert_at,
   input  logic [SAMPLE_BITS-1:0] new_data,
   output logic [SAMPLE_BITS-1:0] tail,
   output logic [SAMPLE_BITS-1:0] next_tail
);

   logic [SAMPLE_BITS-1:0] chain [GRID_MAX];

   // new beat enters at GRID_MAX - n and reaches the tail n beats later
   for (genvar j = 0; j < GRID_MAX; j++) begin : g_cell
      logic [SAMPLE_BITS-1:0] prev;
      if (j == 0) begin : g_head
         assign prev = new_data;
      end else begin : g_body
         assign prev = chain[j-1];
      end
      hass_cell #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .load     (insert_at == XW'(j)),
         .new_data (new_data),
         .prev_data(prev),
         .data_out (chain[j])
      );
   end

   assign tail      = chain[GRID_MAX-1];
   assign next_tail = chain[GRID_MAX-2];

endmodule

// ===== src/hass_update.sv =====
`timescale 1ns / 1ps

module hass_update
   import hass_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SB         = SAMPLE_BITS,
   localparam int LW         = SB + 3,
   localparam int DW         = SB + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  meta_type                    in_meta,
   input  logic signed [LW-1:0]        in_lap,
   input  logic signed [DW-1:0]        in_diff,
   input  logic [SB-1:0]               in_mid,
   input  logic [SB-1:0]               in_samp,
   input  logic signed [COEF_BITS-1:0] left_coef,
   input  logic signed [COEF_BITS-1:0] right_coef,
   input  logic signed [COEF_BITS-1:0] adv_coef,
   output logic                        out_valid,
   output meta_type                    out_meta,
   output logic [SB-1:0]               out_value,
   output logic [SB-1:0]               out_samp
);

   localparam int PW1 = LW + COEF_BITS;
   localparam int PW2 = DW + COEF_BITS;
   localparam int T1W = PW1 - FRAC_BITS;
   localparam int T2W = PW2 - FRAC_BITS;
   localparam int VW  = SB + 6;
   localparam logic signed [PW1-1:0] HALF1 = PW1'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PW2-1:0] HALF2 = PW2'(1) <<< (FRAC_BITS - 1);

   // products
   logic                        v2_ff, v2_in;
   meta_type                    m2_ff;
   logic signed [PW1-1:0]       p1_ff, p1_in;
   logic signed [PW2-1:0]       p2_ff, p2_in;
   logic [SB-1:0]               mid2_ff, samp2_ff;
   logic signed [COEF_BITS-1:0] c_lap, c_adv;

   // rounded terms
   logic                  v3_ff, v3_in;
   meta_type              m3_ff;
   logic signed [T1W-1:0] t1_ff, t1_in;
   logic signed [T2W-1:0] t2_ff, t2_in;
   logic [SB-1:0]         mid3_ff, samp3_ff;
   logic signed [PW1-1:0] p1r;
   logic signed [PW2-1:0] p2r;

   // sum and saturate
   logic                 v4_ff, v4_in;
   meta_type             m4_ff;
   logic [SB-1:0]        val4_ff, val4_in;
   logic [SB-1:0]        samp4_ff;
   logic signed [VW-1:0] sum;
   logic [SB-1:0]        sat;
   logic                 ovf;

   assign c_lap = in_meta.right ? right_coef : left_coef;
   assign c_adv = in_meta.right ? adv_coef : '0;
   assign p1_in = in_lap * c_lap;
   assign p2_in = in_diff * c_adv;
   assign v2_in = in_valid;

   assign p1r   = p1_ff + HALF1;
   assign p2r   = p2_ff + HALF2;
   assign t1_in = p1r[PW1-1:FRAC_BITS];
   assign t2_in = p2r[PW2-1:FRAC_BITS];
   assign v3_in = v2_ff;

   assign sum = {{(VW-SB){mid3_ff[SB-1]}}, mid3_ff}
              + {{(VW-T1W){t1_ff[T1W-1]}}, t1_ff}
              - {{(VW-T2W){t2_ff[T2W-1]}}, t2_ff};
   assign ovf = !((&sum[VW-1:SB-1]) || !(|sum[VW-1:SB-1]));
   assign sat = ovf ? {sum[VW-1], {(SB-1){!sum[VW-1]}}} : sum[SB-1:0];
   assign val4_in = m3_ff.pt_copy ? mid3_ff : sat;
   assign v4_in   = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m2_ff    <= in_meta;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         mid2_ff  <= in_mid;
         samp2_ff <= in_samp;
         m3_ff    <= m2_ff;
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         mid3_ff  <= mid2_ff;
         samp3_ff <= samp2_ff;
         m4_ff    <= m3_ff;
         val4_ff  <= val4_in;
         samp4_ff <= samp3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_meta  = m4_ff;
   assign out_value = val4_ff;
   assign out_samp  = samp4_ff;

endmodule

// ===== src/heat_advection_stencil_step_top.sv =====
`timescale 1ns / 1ps
// channel   ports                            contents
// req       req_tvalid/tready/tdata          sample
// rsp       rsp_tvalid/tready/tdata/tlast    new_value, out_row, out_column; run_last
//           rsp_tuser                        frame_done
// csr       csr_valid/ready/index/data       register writes, always ready
//
// one sample accepted per cycle while req_tready is high; results leave through the registered update pipeline
// during the last grid row a sample gives two results, one result per rsp beat
// line buffers are shift chains of GRID_MAX cells; insert point set by grid_size
// synchronous active-high reset clears control and loads register defaults
// a stalled rsp channel stalls the whole update pipeline and req_tready

module heat_advection_stencil_step_top
   import hass_pkg::*;
#(
   parameter int GRID_MAX    = GRID_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SB         = SAMPLE_BITS,
   localparam int REQ_DW     = ((SB + 7) / 8) * 8,
   localparam int RSP_DW     = ((SB + 2 * POS_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DW-1:0]        req_tdata,  // sample
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DW-1:0]        rsp_tdata,  // new_value, out_row, out_column
   output logic                     rsp_tlast,
   output logic                     rsp_tuser,  // frame_done
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int XW = $clog2(GRID_MAX);
   localparam int NW = $clog2(GRID_MAX + 1);
   localparam int CW = (NW > SIZE_BITS) ? NW : SIZE_BITS;
   localparam int LW = SB + 3;
   localparam int DW = SB + 1;

   // registers
   logic [SIZE_BITS-1:0]        grid_size_ff;
   logic [SIZE_BITS-1:0]        split_ff;
   logic signed [COEF_BITS-1:0] left_coef_ff;
   logic signed [COEF_BITS-1:0] right_coef_ff;
   logic signed [COEF_BITS-1:0] adv_coef_ff;
   logic                        csr_wr;

   logic [SIZE_BITS-1:0] gs_in;
   logic [CW-1:0] gs_ext;
   logic [CW-1:0] n_c;
   logic [NW-1:0] n_ff, n_in;
   logic [XW-1:0] ins_ff, ins_in;
   logic [NW-1:0] n_m1;

   // position
   logic [XW-1:0] row_ff, row_in;
   logic [XW-1:0] col_ff, col_in;
   logic [XW-1:0] r_eff, x_eff;
   logic          x_last, r_last;

   // stencil taps
   logic          accept;
   logic          en;
   logic [SB-1:0] samp;
   logic [SB-1:0] mid, right_tap, up;
   logic [SB-1:0] left_ff;

   // first pipeline stage
   logic                 v1_ff, v1_in;
   meta_type             m1_ff, m1_in;
   logic signed [LW-1:0] lap1_ff, lap1_in;
   logic signed [DW-1:0] diff1_ff, diff1_in;
   logic [SB-1:0]        mid1_ff, samp1_ff;

   // output side
   logic                out_valid;
   meta_type            om;
   logic [SB-1:0]       out_value, out_samp;
   logic                phase_ff, phase_in;
   logic                cur_cp, last_res, rsp_beat;
   logic [POS_BITS-1:0] out_row;
   logic [SB-1:0]       out_val_mux;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff  <= GRID_SIZE_RST;
         split_ff      <= SPLIT_RST;
         left_coef_ff  <= LEFT_COEF_RST;
         right_coef_ff <= RIGHT_COEF_RST;
         adv_coef_ff   <= ADV_COEF_RST;
      end else if (csr_wr) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_SIZE:    grid_size_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_SPLIT_COLUMN: split_ff      <= csr_data[SIZE_BITS-1:0];
            CSR_LEFT_COEF:    left_coef_ff  <= csr_data[COEF_BITS-1:0];
            CSR_RIGHT_COEF:   right_coef_ff <= csr_data[COEF_BITS-1:0];
            CSR_ADV_COEF:     adv_coef_ff   <= csr_data[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // next grid size, so the clamped copy changes with the register
   always_comb begin
      priority if (reset) begin
         gs_in = GRID_SIZE_RST;
      end else if (csr_wr && (csr_index_type'(csr_index) == CSR_GRID_SIZE)) begin
         gs_in = csr_data[SIZE_BITS-1:0];
      end else begin
         gs_in = grid_size_ff;
      end
   end

   // grid size clamped to what the line chains hold
   assign gs_ext = CW'(gs_in);
   always_comb begin
      priority if (gs_ext < CW'(GRID_MIN)) begin
         n_c = CW'(GRID_MIN);
      end else if (gs_ext > CW'(GRID_MAX)) begin
         n_c = CW'(GRID_MAX);
      end else begin
         n_c = gs_ext;
      end
   end
   assign n_in   = NW'(n_c);
   assign ins_in = XW'(CW'(GRID_MAX) - n_c);
   assign n_m1   = n_ff - NW'(1);

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      ins_ff <= ins_in;
   end

   assign samp   = req_tdata[SB-1:0];
   assign accept = req_tvalid && req_tready;

   assign r_eff  = (NW'(row_ff) >= n_ff) ? '0 : row_ff;
   assign x_eff  = (NW'(col_ff) >= n_ff) ? '0 : col_ff;
   assign x_last = (NW'(x_eff) == n_m1);
   assign r_last = (NW'(r_eff) == n_m1);

   always_comb begin
      if (x_last) begin
         col_in = '0;
         row_in = r_last ? '0 : r_eff + XW'(1);
      end else begin
         col_in = x_eff + XW'(1);
         row_in = r_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   hass_line #(
      .GRID_MAX   (GRID_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_middle (
      .clock    (clock),
      .shift_en (accept),
      .insert_at(ins_ff),
      .new_data (samp),
      .tail     (mid),
      .next_tail(right_tap)
   );

   hass_line #(
      .GRID_MAX   (GRID_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_upper (
      .clock    (clock),
      .shift_en (accept),
      .insert_at(ins_ff),
      .new_data (mid),
      .tail     (up),
      .next_tail()
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= mid;
      end
   end

   assign lap1_in = {{(LW-SB){right_tap[SB-1]}}, right_tap}
                  + {{(LW-SB){left_ff[SB-1]}}, left_ff}
                  + {{(LW-SB){up[SB-1]}}, up}
                  + {{(LW-SB){samp[SB-1]}}, samp}
                  - {{(LW-SB-2){mid[SB-1]}}, mid, 2'b00};
   assign diff1_in = {samp[SB-1], samp} - {up[SB-1], up};

   always_comb begin
      m1_in.has_pt  = (r_eff != '0);
      m1_in.has_cp  = r_last;
      m1_in.pt_copy = (r_eff == XW'(1)) || (x_eff == '0) || x_last;
      m1_in.right   = (CW'(x_eff) >= CW'(split_ff));
      m1_in.row     = POS_BITS'(r_eff);
      m1_in.col     = POS_BITS'(x_eff);
      m1_in.done    = r_last && x_last;
   end
   assign v1_in = accept && (m1_in.has_pt || m1_in.has_cp);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff    <= m1_in;
         lap1_ff  <= lap1_in;
         diff1_ff <= diff1_in;
         mid1_ff  <= mid;
         samp1_ff <= samp;
      end
   end

   hass_update #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_meta   (m1_ff),
      .in_lap    (lap1_ff),
      .in_diff   (diff1_ff),
      .in_mid    (mid1_ff),
      .in_samp   (samp1_ff),
      .left_coef (left_coef_ff),
      .right_coef(right_coef_ff),
      .adv_coef  (adv_coef_ff),
      .out_valid (out_valid),
      .out_meta  (om),
      .out_value (out_value),
      .out_samp  (out_samp)
   );

   // point of the row above goes first, then the copied last-row point
   assign cur_cp   = phase_ff || !om.has_pt;
   assign last_res = cur_cp || !om.has_cp;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign en       = !out_valid || (rsp_tready && last_res);
   assign phase_in = rsp_beat ? !last_res : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   assign req_tready  = en;
   assign out_row     = cur_cp ? om.row : om.row - POS_BITS'(1);
   assign out_val_mux = cur_cp ? out_samp : out_value;
   assign rsp_tvalid  = out_valid;
   assign rsp_tdata   = RSP_DW'({om.col, out_row, out_val_mux});
   assign rsp_tlast   = last_res;
   assign rsp_tuser   = cur_cp && om.done;

endmodule

// ===== src/hass_checker.sv =====
`timescale 1ns / 1ps

module hass_checker
   import hass_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int SB         = SAMPLE_BITS,
   localparam int REQ_DW     = ((SB + 7) / 8) * 8,
   localparam int RSP_DW     = ((SB + 2 * POS_BITS + 7) / 8) * 8
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DW-1:0]        req_tdata,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DW-1:0]        rsp_tdata,
   input logic                     rsp_tlast,
   input logic                     rsp_tuser,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic [CSR_IDX_BITS-1:0]  csr_index,
   input logic [CSR_DATA_BITS-1:0] csr_data
);

   localparam int COL_LO = SB + POS_BITS;
   localparam int COL_HI = SB + 2 * POS_BITS - 1;

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // frame end is always the last result of its sample
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame_done without run_last");

   // second result of a sample follows at once, same column
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[COL_HI:COL_LO] == $past(rsp_tdata[COL_HI:COL_LO])))
      else $error("second result of a sample missing or misplaced");

   // nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind heat_advection_stencil_step_top hass_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_hass_checker (.*);
